// ----- rtl/core/balance_tick_supervisor_unit_defines.svh -----
// Assertion macros shared by the balance tick supervisor RTL.
`ifndef BALANCE_TICK_SUPERVISOR_UNIT_DEFINES_SVH
`define BALANCE_TICK_SUPERVISOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bts_pkg.sv -----
// Package: types and constants of the balance tick supervisor.
`timescale 1ns / 1ps
package bts_pkg;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INTEGRATION_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_ANGLE_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_ANGLE_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SETPOINT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED     = 3'd4;

    localparam logic [4:0]         RST_INTEGRATION_TIME = 5'd2;
    localparam logic signed [15:0] RST_STAND_ANGLE_MIN  = 16'sd2000;
    localparam logic signed [15:0] RST_STAND_ANGLE_MAX  = 16'sd7300;
    localparam logic signed [15:0] RST_ANGLE_SETPOINT   = 16'sd4500;
    localparam logic [14:0]        RST_TARGET_SPEED     = 15'd4000;

    localparam logic [5:0]         TICK_MS      = 6'd2;
    localparam logic signed [16:0] UPRIGHT_BAND = 17'sd500;
    localparam logic [14:0]        START_SPEED  = 15'd2000;
    localparam logic [15:0]        RAMP_STEP    = 16'd3;

    typedef struct packed {
        logic [4:0]         integration_time;
        logic signed [15:0] stand_angle_min;
        logic signed [15:0] stand_angle_max;
        logic signed [15:0] angle_setpoint;
        logic [14:0]        target_speed;
    } cfg_t;

    typedef struct packed {
        logic [5:0]  camera_ms;
        logic [5:0]  speed_ms;
        logic        stand_flag;
        logic        start_flag;
        logic        stand_permit;
        logic        start_permit;
        logic [14:0] speed_ramp;
    } state_t;

    typedef struct packed {
        logic               stop_request;
        logic               start_arm;
        logic               stand_arm;
        logic signed [15:0] car_angle;
    } tick_in_t;

    typedef struct packed {
        logic        clear_speed_loop;
        logic [14:0] speed_setpoint;
        logic        started;
        logic        standing;
        logic        motor_enable;
        logic [5:0]  speed_phase_ms;
        logic [5:0]  camera_phase_ms;
        logic        speed_control_due;
        logic        capture_frame;
        logic        start_integration;
    } tick_out_t;

endpackage

// ----- rtl/core/bts_step.sv -----
// Tick step logic: phase counters, fall/stand supervision, ramp and motor gate.
`timescale 1ns / 1ps
module bts_step
    import bts_pkg::*;
#(
    parameter int unsigned DIRECTION_PERIOD_MS = 10,
    parameter int unsigned SPEED_PERIOD_MS     = 40
) (
    input  cfg_t      cfg,
    input  state_t    cur,
    input  tick_in_t  tick,
    output state_t    nxt,
    output tick_out_t res
);

    localparam logic [5:0] DIR_PERIOD = 6'(DIRECTION_PERIOD_MS);
    localparam logic [5:0] SPD_PERIOD = 6'(SPEED_PERIOD_MS);

    logic [5:0]         cam_sum;
    logic [5:0]         spd_sum;
    logic [5:0]         lead;
    logic               fall;
    logic signed [16:0] diff;
    logic               near;
    logic [15:0]        ramp_inc;
    logic               st;

    always_comb begin
        nxt = cur;
        res = '0;

        nxt.stand_permit = cur.stand_permit | tick.stand_arm;
        nxt.start_permit = cur.start_permit | tick.start_arm;

        cam_sum = 6'(cur.camera_ms + TICK_MS);
        spd_sum = 6'(cur.speed_ms + TICK_MS);
        lead    = 6'(DIR_PERIOD - {1'b0, cfg.integration_time});
        res.start_integration = ({1'b0, cfg.integration_time} <= DIR_PERIOD)
                                && (lead == cam_sum);
        res.capture_frame     = (cam_sum >= DIR_PERIOD);
        res.speed_control_due = (spd_sum >= SPD_PERIOD);
        nxt.camera_ms = res.capture_frame ? 6'd0 : cam_sum;
        nxt.speed_ms  = res.speed_control_due ? 6'd0 : spd_sum;

        fall = (tick.car_angle < cfg.stand_angle_min)
               || (tick.car_angle > cfg.stand_angle_max);
        diff = 17'(tick.car_angle) - 17'(cfg.angle_setpoint);
        near = (diff < UPRIGHT_BAND) && (diff > -UPRIGHT_BAND);
        ramp_inc = {1'b0, cur.speed_ramp} + RAMP_STEP;
        st = cur.stand_flag;

        if (fall) begin
            st                   = 1'b0;
            nxt.start_flag       = 1'b0;
            nxt.stand_permit     = 1'b0;
            nxt.start_permit     = 1'b0;
            nxt.speed_ramp       = '0;
            res.clear_speed_loop = 1'b1;
        end else begin
            if (!cur.stand_flag) begin
                if (near) begin
                    if (nxt.stand_permit) begin
                        st = 1'b1;
                    end
                end else begin
                    res.clear_speed_loop = 1'b1;
                end
            end
            if (st && nxt.start_permit) begin
                if (!cur.start_flag) begin
                    nxt.start_flag = 1'b1;
                    nxt.speed_ramp = START_SPEED;
                end else if (ramp_inc > {1'b0, cfg.target_speed}) begin
                    nxt.speed_ramp = cfg.target_speed;
                end else begin
                    nxt.speed_ramp = ramp_inc[14:0];
                end
            end
        end

        res.motor_enable = st && !tick.stop_request;
        nxt.stand_flag   = res.motor_enable;

        res.camera_phase_ms = nxt.camera_ms;
        res.speed_phase_ms  = nxt.speed_ms;
        res.standing        = nxt.stand_flag;
        res.started         = nxt.start_flag;
        res.speed_setpoint  = nxt.speed_ramp;
    end

endmodule

// ----- rtl/core/balance_tick_supervisor_unit.sv -----
// Top level: balance tick supervisor with input and result registers.
//
//  channel   direction  payload (tdata, lowest bit first)
//  s_axis    in         car_angle[15:0] stand_arm[16] start_arm[17] stop_request[18]
//  m_axis    out        34 result bits, see m_tdata
//  cfg       in         cfg_we / cfg_index / cfg_wdata, write only
//
// One tick per cycle unless m_tready stalls: a transfer lands in the input register,
// the step logic runs on it and loads the result register when that stage advances.
// Stalls on m_tready hold both stages; s_tready drops only when both are full.
// aresetn is synchronous; it restores the config reset values and the state.
`timescale 1ns / 1ps
`include "balance_tick_supervisor_unit_defines.svh"
module balance_tick_supervisor_unit
    import bts_pkg::*;
#(
    parameter int unsigned DIRECTION_PERIOD_MS = 10,
    parameter int unsigned SPEED_PERIOD_MS     = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // car_angle[15:0], stand_arm[16], start_arm[17], stop_request[18], zero[23:19]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // start_integration[0], capture_frame[1], speed_control_due[2],
    // camera_phase_ms[8:3], speed_phase_ms[14:9], motor_enable[15], standing[16],
    // started[17], speed_setpoint[32:18], clear_speed_loop[33], zero[39:34]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    tick_in_t  in_reg;
    logic      in_valid_reg;
    tick_out_t out_reg;
    tick_out_t out_next;
    logic      out_valid_reg;
    logic      advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

    bts_step #(
        .DIRECTION_PERIOD_MS(DIRECTION_PERIOD_MS),
        .SPEED_PERIOD_MS    (SPEED_PERIOD_MS)
    ) u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .tick(in_reg),
        .nxt (state_next),
        .res (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.integration_time <= RST_INTEGRATION_TIME;
            cfg_reg.stand_angle_min  <= RST_STAND_ANGLE_MIN;
            cfg_reg.stand_angle_max  <= RST_STAND_ANGLE_MAX;
            cfg_reg.angle_setpoint   <= RST_ANGLE_SETPOINT;
            cfg_reg.target_speed     <= RST_TARGET_SPEED;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INTEGRATION_TIME: cfg_reg.integration_time <= cfg_wdata[4:0];
                REG_STAND_ANGLE_MIN:  cfg_reg.stand_angle_min  <= cfg_wdata;
                REG_STAND_ANGLE_MAX:  cfg_reg.stand_angle_max  <= cfg_wdata;
                REG_ANGLE_SETPOINT:   cfg_reg.angle_setpoint   <= cfg_wdata;
                REG_TARGET_SPEED:     cfg_reg.target_speed     <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.camera_ms    <= '0;
            state_reg.speed_ms     <= '0;
            state_reg.stand_flag   <= 1'b1;
            state_reg.start_flag   <= 1'b0;
            state_reg.stand_permit <= 1'b0;
            state_reg.start_permit <= 1'b0;
            state_reg.speed_ramp   <= '0;
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata[$bits(tick_in_t)-1:0];
        end
        if (advance && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    `BTS_ASSERT_NEXT(a_stage_moves, aclk, aresetn, in_valid_reg && advance, m_tvalid,
        "processed transfer did not reach the result register")
    `BTS_ASSERT_NEXT(a_in_loaded, aclk, aresetn, s_tvalid && s_tready, in_valid_reg,
        "accepted transfer not held in the input register")
    `BTS_ASSERT_NOW(a_motor_stand, aclk, aresetn, m_tvalid && out_reg.motor_enable,
        out_reg.standing, "motor enabled while not standing")
    `BTS_ASSERT_NOW(a_capture_phase, aclk, aresetn, m_tvalid && out_reg.capture_frame,
        out_reg.camera_phase_ms == 6'd0, "camera phase not cleared on capture")

endmodule

// ----- bench/tb_balance_tick_supervisor_unit.sv -----
// Testbench for balance_tick_supervisor_unit: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps
module tb_balance_tick_supervisor_unit
    import bts_pkg::*;
;

    localparam int DIR_PERIOD = 10;
    localparam int SPD_PERIOD = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ANGLE_LIMIT = 18000;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    // car_angle[15:0], stand_arm[16], start_arm[17], stop_request[18], zero[23:19]
    logic [IN_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // start_integration[0], capture_frame[1], speed_control_due[2], camera_phase_ms[8:3],
    // speed_phase_ms[14:9], motor_enable[15], standing[16], started[17],
    // speed_setpoint[32:18], clear_speed_loop[33], zero[39:34]
    logic [OUT_TDATA_W-1:0] m_tdata;

    // predictor copy of configuration
    int lead_ms;
    int win_lo;
    int win_hi;
    int balance_pt;
    int speed_goal;

    // predictor copy of state
    logic [5:0] cam_phase;
    logic [5:0] spd_phase;
    logic is_standing;
    logic is_started;
    logic stand_permit;
    logic start_permit;
    logic [14:0] ramp;

    tick_out_t expected_ticks[$];
    int errors = 0;
    int cycles = 0;
    bit steady = 1'b0;

    balance_tick_supervisor_unit #(
        .DIRECTION_PERIOD_MS(DIR_PERIOD),
        .SPEED_PERIOD_MS(SPD_PERIOD)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    function automatic int clamp_angle(int a);
        if (a > ANGLE_LIMIT) return ANGLE_LIMIT;
        if (a < -ANGLE_LIMIT) return -ANGLE_LIMIT;
        return a;
    endfunction

    function automatic tick_in_t make_tick(int angle, bit stand, bit start, bit stop);
        tick_in_t t;
        t.car_angle = angle[15:0];
        t.stand_arm = stand;
        t.start_arm = start;
        t.stop_request = stop;
        return t;
    endfunction

    function automatic void reset_model();
        lead_ms = int'(RST_INTEGRATION_TIME);
        win_lo = int'(RST_STAND_ANGLE_MIN);
        win_hi = int'(RST_STAND_ANGLE_MAX);
        balance_pt = int'(RST_ANGLE_SETPOINT);
        speed_goal = int'(RST_TARGET_SPEED);
        cam_phase = '0;
        spd_phase = '0;
        is_standing = 1'b1;
        is_started = 1'b0;
        stand_permit = 1'b0;
        start_permit = 1'b0;
        ramp = '0;
    endfunction

    function automatic tick_out_t advance_tick(tick_in_t t);
        tick_out_t o;
        int angle;
        int lead;
        int diff;
        int ramp_next;
        o = '0;
        angle = int'(t.car_angle);
        if (t.stand_arm) stand_permit = 1'b1;
        if (t.start_arm) start_permit = 1'b1;

        cam_phase = cam_phase + TICK_MS;
        spd_phase = spd_phase + TICK_MS;
        lead = DIR_PERIOD - lead_ms;
        if (lead >= 0 && lead == int'(cam_phase)) o.start_integration = 1'b1;
        if (int'(cam_phase) >= DIR_PERIOD) begin
            o.capture_frame = 1'b1;
            cam_phase = '0;
        end
        if (int'(spd_phase) >= SPD_PERIOD) begin
            o.speed_control_due = 1'b1;
            spd_phase = '0;
        end

        if (angle < win_lo || angle > win_hi) begin
            is_standing = 1'b0;
            is_started = 1'b0;
            stand_permit = 1'b0;
            start_permit = 1'b0;
            ramp = '0;
            o.clear_speed_loop = 1'b1;
        end else begin
            if (!is_standing) begin
                diff = angle - balance_pt;
                if (diff < 500 && diff > -500) begin
                    if (stand_permit) is_standing = 1'b1;
                end else begin
                    o.clear_speed_loop = 1'b1;
                end
            end
            if (is_standing && start_permit) begin
                if (!is_started) begin
                    is_started = 1'b1;
                    ramp = START_SPEED;
                end else begin
                    ramp_next = int'(ramp) + 3;
                    if (ramp_next > speed_goal) ramp_next = speed_goal;
                    ramp = ramp_next[14:0];
                end
            end
        end

        if (is_standing && !t.stop_request) o.motor_enable = 1'b1;
        else is_standing = 1'b0;

        o.camera_phase_ms = cam_phase;
        o.speed_phase_ms = spd_phase;
        o.standing = is_standing;
        o.started = is_started;
        o.speed_setpoint = ramp;
        return o;
    endfunction

    task automatic cmp_field(input string name, input logic [14:0] e, input logic [14:0] a);
        if (a !== e) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tick_out_t got;
        tick_out_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(tick_out_t)-1:0];
            if (expected_ticks.size() == 0) begin
                $error("result transfer with no tick outstanding");
                errors++;
            end else begin
                exp = expected_ticks.pop_front();
                cmp_field("start_integration", 15'(exp.start_integration),
                          15'(got.start_integration));
                cmp_field("capture_frame", 15'(exp.capture_frame),
                          15'(got.capture_frame));
                cmp_field("speed_control_due", 15'(exp.speed_control_due),
                          15'(got.speed_control_due));
                cmp_field("camera_phase_ms", 15'(exp.camera_phase_ms),
                          15'(got.camera_phase_ms));
                cmp_field("speed_phase_ms", 15'(exp.speed_phase_ms),
                          15'(got.speed_phase_ms));
                cmp_field("motor_enable", 15'(exp.motor_enable),
                          15'(got.motor_enable));
                cmp_field("standing", 15'(exp.standing), 15'(got.standing));
                cmp_field("started", 15'(exp.started), 15'(got.started));
                cmp_field("speed_setpoint", exp.speed_setpoint, got.speed_setpoint);
                cmp_field("clear_speed_loop", 15'(exp.clear_speed_loop),
                          15'(got.clear_speed_loop));
            end
        end
    end

    task automatic send_tick(tick_in_t t);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 33) ? int'($urandom_range(1, 3)) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - $bits(tick_in_t)){1'b0}}, t};
        do @(posedge aclk); while (!s_tready);
        expected_ticks.push_back(advance_tick(t));
    endtask

    // drop valid, wait for all results, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        logic [15:0] v;
        v = value[15:0];
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INTEGRATION_TIME: lead_ms = int'(v[4:0]);
            REG_STAND_ANGLE_MIN: win_lo = int'(signed'(v));
            REG_STAND_ANGLE_MAX: win_hi = int'(signed'(v));
            REG_ANGLE_SETPOINT: balance_pt = int'(signed'(v));
            REG_TARGET_SPEED: speed_goal = int'(v[14:0]);
            default: ;
        endcase
    endtask

    task automatic test_fall_and_recover();
        send_tick(make_tick(4500, 0, 0, 0));
        send_tick(make_tick(-18000, 0, 0, 0));
        send_tick(make_tick(18000, 1, 1, 0));
        send_tick(make_tick(4500, 0, 0, 0));
        send_tick(make_tick(6000, 0, 0, 0));
        send_tick(make_tick(5000, 1, 0, 0));
        send_tick(make_tick(4001, 0, 0, 0));
        settle();
    endtask

    task automatic test_start_ramp();
        send_tick(make_tick(4500, 0, 1, 0));
        repeat (3) send_tick(make_tick(4500, 0, 0, 0));
        send_tick(make_tick(4500, 0, 0, 1));
        send_tick(make_tick(4500, 0, 0, 0));
        send_tick(make_tick(2000, 0, 0, 0));
        send_tick(make_tick(7300, 0, 0, 0));
        send_tick(make_tick(1999, 0, 0, 0));
        send_tick(make_tick(7301, 0, 0, 0));
        settle();
    endtask

    task automatic test_config_corners();
        // ramp above a lowered target drops to it
        write_reg(REG_TARGET_SPEED, 1000);
        send_tick(make_tick(4500, 1, 1, 0));
        send_tick(make_tick(4500, 0, 0, 0));
        send_tick(make_tick(4500, 0, 0, 0));
        settle();
        write_reg(REG_INTEGRATION_TIME, 0);
        repeat (6) send_tick(make_tick(4500, 0, 0, 0));
        settle();
        write_reg(REG_INTEGRATION_TIME, 30);
        repeat (6) send_tick(make_tick(4500, 0, 0, 0));
        settle();
        write_reg(REG_INTEGRATION_TIME, 10);
        repeat (6) send_tick(make_tick(4500, 0, 0, 0));
        settle();
        // inverted window: always a fall
        write_reg(REG_STAND_ANGLE_MIN, 100);
        write_reg(REG_STAND_ANGLE_MAX, -100);
        send_tick(make_tick(0, 1, 1, 0));
        send_tick(make_tick(0, 0, 0, 0));
        settle();
        write_reg(3'd5, 'hFFFF);
        write_reg(3'd6, 'h1234);
        write_reg(3'd7, 0);
        write_reg(REG_STAND_ANGLE_MIN, -18000);
        write_reg(REG_STAND_ANGLE_MAX, 18000);
        write_reg(REG_ANGLE_SETPOINT, -18000);
        write_reg(REG_TARGET_SPEED, 25500);
        send_tick(make_tick(-18000, 1, 1, 0));
        send_tick(make_tick(18000, 0, 0, 0));
        settle();
        write_reg(REG_ANGLE_SETPOINT, 18000);
        write_reg(REG_TARGET_SPEED, 0);
        send_tick(make_tick(17501, 1, 1, 0));
        send_tick(make_tick(18000, 0, 0, 0));
        send_tick(make_tick(-1, 0, 0, 0));
        settle();
    endtask

    function automatic tick_in_t random_tick();
        int pick;
        int a;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            a = balance_pt + int'($urandom_range(0, 1200)) - 600;
        end else if (pick < 75 && win_lo <= win_hi) begin
            a = win_lo + int'($urandom_range(0, win_hi - win_lo));
        end else if (pick < 85) begin
            if ($urandom_range(0, 1)) a = win_lo - 1 - int'($urandom_range(0, 50));
            else a = win_hi + 1 + int'($urandom_range(0, 50));
        end else begin
            a = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
        end
        return make_tick(clamp_angle(a), $urandom_range(0, 99) < 15,
                         $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 4);
    endfunction

    task automatic test_random_phases();
        int bp;
        for (int phase = 0; phase < 6; phase++) begin
            bp = int'($urandom_range(0, 24000)) - 12000;
            write_reg(REG_INTEGRATION_TIME, $urandom_range(0, 30));
            write_reg(REG_ANGLE_SETPOINT, bp);
            write_reg(REG_STAND_ANGLE_MIN, clamp_angle(bp - int'($urandom_range(500, 6000))));
            write_reg(REG_STAND_ANGLE_MAX, clamp_angle(bp + int'($urandom_range(500, 6000))));
            if (phase == 5) write_reg(REG_TARGET_SPEED, $urandom_range(0, 25500));
            else write_reg(REG_TARGET_SPEED, $urandom_range(1900, 2600));
            steady = (phase == 2);
            repeat (215) send_tick(random_tick());
            settle();
            steady = 1'b0;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        reset_model();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_fall_and_recover();
        test_start_ramp();
        test_config_corners();
        test_random_phases();

        repeat (10) @(posedge aclk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
